### sv/chi_squared_density_unit_assert.svh
// assertion macros used by the checker file
`ifndef CHI_SQUARED_DENSITY_UNIT_ASSERT_SVH
`define CHI_SQUARED_DENSITY_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define CSD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CSD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/csd_pkg.sv
// ----------------------------------------------------------------------------
// csd_pkg
// types, constants and constant tables of the chi-squared density unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package csd_pkg;

    localparam int MAX_DIMS  = 2;
    localparam int FRAC_BITS = 16;
    localparam int LOG_FRAC  = 24;
    localparam int EXP_FRAC  = 25;
    localparam int Y_W       = 48;

    localparam logic [31:0] LOG2E_Q31 = 32'd3098164010;
    localparam logic [31:0] ONE_Q     = 32'(64'd1 << FRAC_BITS);
    localparam logic [31:0] HALF_Q    = 32'(64'd1 << (FRAC_BITS - 1));

    // exp2 saturation limits and bias, Q.25
    localparam logic signed [Y_W-1:0] Y_HI =
        Y_W'(longint'(32 - FRAC_BITS) * (longint'(1) << EXP_FRAC));
    localparam logic signed [Y_W-1:0] Y_LO =
        Y_W'(-longint'(FRAC_BITS + 2) * (longint'(1) << EXP_FRAC));
    localparam logic signed [Y_W-1:0] Y_BIAS =
        Y_W'(longint'(64) * (longint'(1) << EXP_FRAC));
    localparam logic signed [7:0] S_OFS = 8'(94 - FRAC_BITS);

    typedef enum logic [2:0] {
        REG_MIN0  = 3'd0,
        REG_MIN1  = 3'd1,
        REG_INV0  = 3'd2,
        REG_INV1  = 3'd3,
        REG_KAP0  = 3'd4,
        REG_KAP1  = 3'd5,
        REG_NORM0 = 3'd6,
        REG_NORM1 = 3'd7
    } csd_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ARG,
        ST_CHECK,
        ST_NORM,
        ST_SQR,
        ST_LACC,
        ST_KMUL,
        ST_CMUL,
        ST_EXP_INIT,
        ST_EXP,
        ST_EXP_FIN,
        ST_DONE
    } csd_state_t;

    typedef enum logic [1:0] {
        LOG_PROD,
        LOG_NORM,
        LOG_ARG
    } csd_log_sel_t;

    typedef struct packed {
        logic [31:0] minimum;
        logic [31:0] inv_sigma;
        logic [6:0]  kappa;
        logic [31:0] norm;
    } csd_dim_cfg_t;

    typedef struct packed {
        logic [31:0] density;
        logic        domain_error;
    } csd_res_t;

    typedef struct packed {
        logic idle;
        logic res_valid;
    } csd_stat_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bitv;
        int k;
        v    = v_in;
        res  = '0;
        bitv = 64'd1 << 62;
        for (k = 0; k < 32; k++)
            if (bitv > v)
                bitv = bitv >> 2;
        for (k = 0; k < 32; k++) begin
            if (bitv != 64'd0)
            begin
                if (v >= res + bitv)
                begin
                    v   = v - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                    res = res >> 1;
                bitv = bitv >> 2;
            end
        end
        return res;
    endfunction

    // 2^(2^-idx) in Q2.30, built by repeated square roots
    function automatic logic [31:0] pow_const(input int idx);
        logic [63:0] c;
        int i;
        c = 64'd1 << 31;
        for (i = 1; i <= idx; i++)
            c = isqrt64(c << 30);
        return c[31:0];
    endfunction

    localparam logic [31:0] POW_TAB [0:EXP_FRAC] = '{
        pow_const(0),  pow_const(1),  pow_const(2),  pow_const(3),
        pow_const(4),  pow_const(5),  pow_const(6),  pow_const(7),
        pow_const(8),  pow_const(9),  pow_const(10), pow_const(11),
        pow_const(12), pow_const(13), pow_const(14), pow_const(15),
        pow_const(16), pow_const(17), pow_const(18), pow_const(19),
        pow_const(20), pow_const(21), pow_const(22), pow_const(23),
        pow_const(24), pow_const(25)
    };

endpackage

### sv/csd_in_if.sv
// ----------------------------------------------------------------------------
// csd_in_if
// input item channel: one coordinate and the last-dimension mark
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface csd_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] coordinate;
    logic        last_dimension;

    modport source (output valid, coordinate, last_dimension, input ready);
    modport sink   (input valid, coordinate, last_dimension, output ready);
endinterface

### sv/csd_out_if.sv
// ----------------------------------------------------------------------------
// csd_out_if
// result item channel: density and domain error flag
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface csd_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] density;
    logic        domain_error;

    modport source (output valid, density, domain_error, input ready);
    modport sink   (input valid, density, domain_error, output ready);
endinterface

### sv/csd_core.sv
// ----------------------------------------------------------------------------
// csd_core
// sequencer and shared multiplier datapath for one coordinate at a time
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csd_core
    import csd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [31:0]  coordinate,
    input  logic         last_dimension,
    input  csd_dim_cfg_t cfg,
    input  logic         res_free,
    output logic         dim,
    output csd_stat_t    stat,
    output csd_res_t     res
);

    csd_state_t   state_reg, state_next;
    csd_log_sel_t sel_reg, sel_next;
    logic [31:0]  coord_reg, coord_next;
    logic         last_reg, last_next;
    logic         dim_reg, dim_next;
    logic [31:0]  prod_reg, prod_next;
    logic         err_reg, err_next;
    logic [31:0]  arg_reg, arg_next;
    logic signed [Y_W-1:0] y_reg, y_next;
    logic [31:0]  m_reg, m_next;
    logic [4:0]   lz_reg, lz_next;
    logic [23:0]  frac_reg, frac_next;
    logic [4:0]   cnt_reg, cnt_next;
    logic signed [31:0] l_reg, l_next;
    logic [24:0]  f_reg, f_next;
    logic signed [7:0]  s_reg, s_next;

    logic [32:0]  mul_a;
    logic [31:0]  mul_b;
    logic [64:0]  mul_p;
    logic signed [32:0] diff;
    logic [64:0]  a_full;
    logic [6:0]   kap_eff;
    logic [4:0]   sh;
    logic [32:0]  sq;
    logic signed [31:0] l_val;
    logic [31:0]  abs_l;
    logic signed [Y_W-1:0] yb;
    logic [5:0]   rsh;
    logic [64:0]  r_wide;

    assign kap_eff = (cfg.kappa < 7'd2) ? 7'd2 : cfg.kappa;
    assign diff    = $signed({coord_reg[31], coord_reg}) - $signed({cfg.minimum[31], cfg.minimum});
    assign a_full  = mul_p >> FRAC_BITS;
    assign sh      = 5'd16 >> cnt_reg[2:0];
    assign sq      = mul_p[63:31];
    assign l_val   = ((int'(31 - FRAC_BITS) - int'(lz_reg)) <<< LOG_FRAC) + int'(frac_reg);
    assign abs_l   = l_reg[31] ? 32'(-l_reg) : 32'(l_reg);
    assign yb      = y_reg + Y_BIAS;
    assign rsh     = 6'(-s_reg);

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_ARG:
            begin
                mul_a = diff[32:0];
                mul_b = cfg.inv_sigma;
            end
            ST_SQR:
            begin
                mul_a = {1'b0, m_reg};
                mul_b = m_reg;
            end
            ST_KMUL:
            begin
                mul_a = {1'b0, abs_l};
                mul_b = {25'd0, kap_eff - 7'd2};
            end
            ST_CMUL:
            begin
                mul_a = {1'b0, arg_reg};
                mul_b = LOG2E_Q31;
            end
            ST_EXP:
            begin
                mul_a = {1'b0, m_reg};
                mul_b = POW_TAB[cnt_reg];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = 65'(mul_a) * 65'(mul_b);

    always_comb
    begin
        if (s_reg >= 0)
            r_wide = 65'(m_reg) << s_reg[0];
        else
            r_wide = (65'(m_reg) + (65'd1 << (rsh - 6'd1))) >> rsh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            dim_reg   <= 1'b0;
            prod_reg  <= ONE_Q;
            err_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            dim_reg   <= dim_next;
            prod_reg  <= prod_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg   <= sel_next;
        coord_reg <= coord_next;
        last_reg  <= last_next;
        arg_reg   <= arg_next;
        y_reg     <= y_next;
        m_reg     <= m_next;
        lz_reg    <= lz_next;
        frac_reg  <= frac_next;
        cnt_reg   <= cnt_next;
        l_reg     <= l_next;
        f_reg     <= f_next;
        s_reg     <= s_next;
    end

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        coord_next = coord_reg;
        last_next  = last_reg;
        dim_next   = dim_reg;
        prod_next  = prod_reg;
        err_next   = err_reg;
        arg_next   = arg_reg;
        y_next     = y_reg;
        m_next     = m_reg;
        lz_next    = lz_reg;
        frac_next  = frac_reg;
        cnt_next   = cnt_reg;
        l_next     = l_reg;
        f_next     = f_reg;
        s_next     = s_reg;
        stat.idle      = 1'b0;
        stat.res_valid = 1'b0;
        res.density      = err_reg ? 32'd0 : prod_reg;
        res.domain_error = err_reg;

        case (state_reg)
            ST_IDLE:
            begin
                stat.idle = 1'b1;
                if (start)
                begin
                    coord_next = coordinate;
                    last_next  = last_dimension;
                    state_next = ST_ARG;
                end
            end
            ST_ARG:
            begin
                if (err_reg)
                    state_next = ST_DONE;
                else if (diff < 0)
                begin
                    err_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    arg_next   = (|a_full[64:32]) ? 32'hFFFF_FFFF : a_full[31:0];
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (prod_reg == 32'd0 || cfg.norm == 32'd0 ||
                    (arg_reg == 32'd0 && kap_eff > 7'd2))
                begin
                    prod_next  = 32'd0;
                    state_next = ST_DONE;
                end
                else
                begin
                    y_next     = '0;
                    sel_next   = LOG_PROD;
                    m_next     = prod_reg;
                    lz_next    = '0;
                    cnt_next   = '0;
                    state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                // binary search for the leading one
                if ((m_reg >> (6'd32 - 6'(sh))) == 32'd0)
                begin
                    m_next  = m_reg << sh;
                    lz_next = lz_reg + sh;
                end
                if (cnt_reg == 5'd4)
                begin
                    cnt_next   = '0;
                    frac_next  = '0;
                    state_next = ST_SQR;
                end
                else
                    cnt_next = cnt_reg + 5'd1;
            end
            ST_SQR:
            begin
                frac_next = {frac_reg[22:0], sq[32]};
                m_next    = sq[32] ? sq[32:1] : sq[31:0];
                if (cnt_reg == 5'(LOG_FRAC - 1))
                    state_next = ST_LACC;
                else
                    cnt_next = cnt_reg + 5'd1;
            end
            ST_LACC:
            begin
                case (sel_reg)
                    LOG_PROD:
                    begin
                        y_next     = y_reg + ({{(Y_W-32){l_val[31]}}, l_val} <<< 1);
                        sel_next   = LOG_NORM;
                        m_next     = cfg.norm;
                        lz_next    = '0;
                        cnt_next   = '0;
                        state_next = ST_NORM;
                    end
                    LOG_NORM:
                    begin
                        y_next = y_reg + ({{(Y_W-32){l_val[31]}}, l_val} <<< 1);
                        if (arg_reg != 32'd0)
                        begin
                            sel_next   = LOG_ARG;
                            m_next     = arg_reg;
                            lz_next    = '0;
                            cnt_next   = '0;
                            state_next = ST_NORM;
                        end
                        else
                            state_next = ST_EXP_INIT;
                    end
                    default:
                    begin
                        l_next     = l_val;
                        state_next = ST_KMUL;
                    end
                endcase
            end
            ST_KMUL:
            begin
                if (l_reg[31])
                    y_next = y_reg - $signed(mul_p[Y_W-1:0]);
                else
                    y_next = y_reg + $signed(mul_p[Y_W-1:0]);
                state_next = ST_CMUL;
            end
            ST_CMUL:
            begin
                y_next     = y_reg - $signed({6'd0, mul_p[64:23]});
                state_next = ST_EXP_INIT;
            end
            ST_EXP_INIT:
            begin
                if (y_reg >= Y_HI)
                begin
                    prod_next  = 32'hFFFF_FFFF;
                    state_next = ST_DONE;
                end
                else if (y_reg < Y_LO)
                begin
                    prod_next  = 32'd0;
                    state_next = ST_DONE;
                end
                else
                begin
                    f_next     = yb[24:0];
                    s_next     = $signed({1'b0, yb[31:25]}) - S_OFS;
                    m_next     = 32'h4000_0000;
                    cnt_next   = 5'd1;
                    state_next = ST_EXP;
                end
            end
            ST_EXP:
            begin
                if (f_reg[24])
                    m_next = 32'((mul_p + 65'h2000_0000) >> 30);
                f_next = f_reg << 1;
                if (cnt_reg == 5'(EXP_FRAC))
                    state_next = ST_EXP_FIN;
                else
                    cnt_next = cnt_reg + 5'd1;
            end
            ST_EXP_FIN:
            begin
                prod_next  = (|r_wide[64:32]) ? 32'hFFFF_FFFF : r_wide[31:0];
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!last_reg)
                begin
                    dim_next   = (MAX_DIMS > 1);
                    state_next = ST_IDLE;
                end
                else if (res_free)
                begin
                    stat.res_valid = 1'b1;
                    prod_next      = ONE_Q;
                    err_next       = 1'b0;
                    dim_next       = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign dim = dim_reg;

endmodule

### sv/chi_squared_density_unit.sv
// ----------------------------------------------------------------------------
// chi_squared_density_unit
// product of chi-squared densities over up to two dimensions, Q16.16
// ----------------------------------------------------------------------------
// usage
//   in_item carries one coordinate per item; last_dimension marks the final
//   coordinate of a point. the first item of a point uses the dimension 0
//   registers, every later one the dimension 1 registers.
//   out_item gives one item per point (density, domain_error) on the item
//   that carries the mark; other items give nothing.
//   the config port (cfg_we, cfg_index, cfg_data) writes a register;
//   write only while no item is in flight.
// sequencing
//   a coordinate goes through up to three log2 evaluations (product, norm,
//   arg) and an exp2 on the sequencer; the arg log2 is skipped when arg is
//   zero, and all are skipped when the product is forced to zero or for a
//   coordinate at or after a domain error. the sequencer passes through idle
//   before the next item is taken. the 24-step squaring loop of each log2 and
//   the 25-step exp2 loop run on the single shared multiplier. in_item.ready
//   is high only while the sequencer is idle.
// reset and stall
//   reset loads the register defaults and starts a fresh point. the result
//   sits in an output register; the next item is accepted while it waits,
//   and the sequencer only holds at its end if that register is still full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chi_squared_density_unit
    import csd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    csd_in_if.sink      in_item,
    csd_out_if.source   out_item,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    // configuration registers
    logic [31:0] min0_reg, min1_reg;
    logic [31:0] inv0_reg, inv1_reg;
    logic [6:0]  kap0_reg, kap1_reg;
    logic [31:0] norm0_reg, norm1_reg;

    // output register
    logic        out_valid_reg, out_valid_next;
    csd_res_t    out_res_reg;

    csd_dim_cfg_t dim_cfg;
    csd_stat_t    stat;
    csd_res_t     core_res;
    logic         core_dim;
    logic         res_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min0_reg  <= 32'd0;
            min1_reg  <= 32'd0;
            inv0_reg  <= ONE_Q;
            inv1_reg  <= ONE_Q;
            kap0_reg  <= 7'd2;
            kap1_reg  <= 7'd2;
            norm0_reg <= HALF_Q;
            norm1_reg <= HALF_Q;
        end
        else if (cfg_we)
        begin
            case (csd_reg_t'(cfg_index))
                REG_MIN0:  min0_reg  <= cfg_data;
                REG_MIN1:  min1_reg  <= cfg_data;
                REG_INV0:  inv0_reg  <= cfg_data;
                REG_INV1:  inv1_reg  <= cfg_data;
                REG_KAP0:  kap0_reg  <= cfg_data[6:0];
                REG_KAP1:  kap1_reg  <= cfg_data[6:0];
                REG_NORM0: norm0_reg <= cfg_data;
                REG_NORM1: norm1_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    // register set of the current dimension
    always_comb
    begin
        if (core_dim)
            dim_cfg = '{minimum: min1_reg, inv_sigma: inv1_reg,
                        kappa: kap1_reg, norm: norm1_reg};
        else
            dim_cfg = '{minimum: min0_reg, inv_sigma: inv0_reg,
                        kappa: kap0_reg, norm: norm0_reg};
    end

    // the output register frees up in the same cycle it is taken
    assign res_free = !out_valid_reg || out_item.ready;

    csd_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (in_item.valid && stat.idle),
        .coordinate     (in_item.coordinate),
        .last_dimension (in_item.last_dimension),
        .cfg            (dim_cfg),
        .res_free       (res_free),
        .dim            (core_dim),
        .stat           (stat),
        .res            (core_res)
    );

    always_comb
    begin
        if (stat.res_valid)
            out_valid_next = 1'b1;
        else if (out_item.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (stat.res_valid)
            out_res_reg <= core_res;
    end

    assign in_item.ready         = stat.idle;
    assign out_item.valid        = out_valid_reg;
    assign out_item.density      = out_res_reg.density;
    assign out_item.domain_error = out_res_reg.domain_error;

endmodule

### sv/csd_checker.sv
// ----------------------------------------------------------------------------
// csd_checker
// port-level checks of the chi-squared density unit, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "chi_squared_density_unit_assert.svh"

module csd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_density,
    input logic        out_error
);

    // stalled result holds
    `CSD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_density) && $stable(out_error), "stalled result changed")

    // a domain error always reports zero density
    `CSD_ASSERT_IMP(a_err_zero, out_valid && out_error, out_density == 32'd0, "error result with nonzero density")

    // the sequencer is busy right after taking an item
    `CSD_ASSERT_NXT(a_busy, in_valid && in_ready, !in_ready, "ready right after accept")

    // no result can come out the cycle after an item enters an empty output
    `CSD_ASSERT_NXT(a_no_instant, in_valid && in_ready && !out_valid, !out_valid, "result too early")

endmodule

bind chi_squared_density_unit csd_checker u_csd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_item.valid),
    .in_ready    (in_item.ready),
    .out_valid   (out_item.valid),
    .out_ready   (out_item.ready),
    .out_density (out_item.density),
    .out_error   (out_item.domain_error)
);
